@@ rtl/arrss_pkg.sv @@
// ----------------------------------------------------------------------------
// arrss_pkg: shared types and constants of the ADC scan sequencer
// Channel count, field widths, operation and register codes, and the
// sequencer state type.
// ----------------------------------------------------------------------------
package arrss_pkg;

    // Channel count and field widths
    localparam int NUM_CHANNELS = 6;
    localparam int SAMPLE_BITS  = 10;
    localparam int CH_BITS      = 3;
    localparam int MASK_BITS    = 6;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CH_BITS-1:0] LAST_CH = CH_BITS'(NUM_CHANNELS - 1);

    // Input operation codes
    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_DRAIN   = 1'b1;

    // Result kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_VALUE  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLED_MASK  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_CHANNEL = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN_SCAN,
        ST_DRAIN_EMIT
    } state_t;

    // Requests from the sequencer to the channel store
    typedef struct packed {
        logic               wr_en;
        logic [CH_BITS-1:0] wr_addr;
        logic               rd_en;
        logic [CH_BITS-1:0] rd_addr;
        logic               clr_en;
        logic [CH_BITS-1:0] clr_addr;
    } store_req_t;

    // Step a channel number upward, wrapping after the highest channel
    function automatic logic [CH_BITS-1:0] next_ch(input logic [CH_BITS-1:0] ch);
        logic [CH_BITS-1:0] res;
        if (ch == LAST_CH)
        begin
            res = '0;
        end
        else
        begin
            res = ch + CH_BITS'(1);
        end
        return res;
    endfunction

endpackage

@@ rtl/adc_round_robin_scan_sequencer.sv @@
// ----------------------------------------------------------------------------
// adc_round_robin_scan_sequencer: round-robin channel sequencer for an ADC
// Stores each conversion for the current channel, steps to the next enabled
// channel (if any) and reports it; a drain delivers every pending value.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  opcode, sample
//   out       output     out_valid/out_stall  kind, next_channel, round_done,
//                                              channel, value, last
//   cfg       input      cfg_we               cfg_index, cfg_data
//
// In a conversion the search tests one channel per cycle until it finds one.
// A drain scans upward from channel 0 and reads each pending value through
// the registered read port of the sample store before it is delivered.
// Reset clears the current channel, the pending marks and both registers.
// A held result stalls the sequencer only when it must load the next one.
// ----------------------------------------------------------------------------
module adc_round_robin_scan_sequencer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input items
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 opcode,
    input  logic [arrss_pkg::SAMPLE_BITS-1:0]    sample,
    // results
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 kind,
    output logic [arrss_pkg::CH_BITS-1:0]        next_channel,
    output logic                                 round_done,
    output logic [arrss_pkg::CH_BITS-1:0]        channel,
    output logic [arrss_pkg::SAMPLE_BITS-1:0]    value,
    output logic                                 last,
    // configuration
    input  logic                                 cfg_we,
    input  logic [arrss_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [arrss_pkg::MASK_BITS-1:0]      cfg_data
);

    arrss_pkg::state_t                    state_reg;
    arrss_pkg::state_t                    state_next;
    logic [arrss_pkg::MASK_BITS-1:0]      mask_reg;
    logic [arrss_pkg::CH_BITS-1:0]        first_reg;
    logic [arrss_pkg::CH_BITS-1:0]        cur_reg;
    logic [arrss_pkg::CH_BITS-1:0]        cur_next;
    logic [arrss_pkg::CH_BITS-1:0]        idx_reg;
    logic [arrss_pkg::CH_BITS-1:0]        idx_next;
    logic [arrss_pkg::CH_BITS-1:0]        cnt_reg;
    logic [arrss_pkg::CH_BITS-1:0]        cnt_next;

    logic                                 out_valid_reg;
    logic                                 kind_reg;
    logic [arrss_pkg::CH_BITS-1:0]        next_channel_reg;
    logic                                 round_done_reg;
    logic [arrss_pkg::CH_BITS-1:0]        channel_reg;
    logic [arrss_pkg::SAMPLE_BITS-1:0]    value_reg;
    logic                                 last_reg;

    arrss_pkg::store_req_t                store_req;
    logic [arrss_pkg::SAMPLE_BITS-1:0]    rd_data;
    logic [arrss_pkg::NUM_CHANNELS-1:0]   pending;
    logic [arrss_pkg::NUM_CHANNELS-1:0]   pending_above;

    logic                                 in_xfer;
    logic                                 out_free;
    logic                                 load_report;
    logic                                 load_value;
    logic                                 hit;

    arrss_chan_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .wr_data (sample),
        .rd_data (rd_data),
        .pending (pending)
    );

    assign in_stall = (state_reg != arrss_pkg::ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Pending channels above the one being delivered
    always_comb
    begin
        for (int i = 0; i < arrss_pkg::NUM_CHANNELS; i++)
        begin
            pending_above[i] = pending[i] && (arrss_pkg::CH_BITS'(i) > idx_reg);
        end
    end

    // Search test: candidate enabled, or the full circle is done
    assign hit = mask_reg[idx_reg] || (cnt_reg == arrss_pkg::LAST_CH);

    // Sequencer next state and store requests
    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        load_report = 1'b0;
        load_value  = 1'b0;
        store_req   = '0;

        unique case (state_reg)
            arrss_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (opcode == arrss_pkg::OP_CONVERT)
                    begin
                        store_req.wr_en   = 1'b1;
                        store_req.wr_addr = cur_reg;
                        idx_next          = arrss_pkg::next_ch(cur_reg);
                        cnt_next          = '0;
                        state_next        = arrss_pkg::ST_SEARCH;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = arrss_pkg::ST_DRAIN_SCAN;
                    end
                end
            end

            arrss_pkg::ST_SEARCH:
            begin
                if (hit)
                begin
                    if (out_free)
                    begin
                        load_report = 1'b1;
                        cur_next    = idx_reg;
                        state_next  = arrss_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    idx_next = arrss_pkg::next_ch(idx_reg);
                    cnt_next = cnt_reg + arrss_pkg::CH_BITS'(1);
                end
            end

            arrss_pkg::ST_DRAIN_SCAN:
            begin
                if (pending[idx_reg])
                begin
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = idx_reg;
                    state_next        = arrss_pkg::ST_DRAIN_EMIT;
                end
                else if (idx_reg == arrss_pkg::LAST_CH)
                begin
                    state_next = arrss_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + arrss_pkg::CH_BITS'(1);
                end
            end

            arrss_pkg::ST_DRAIN_EMIT:
            begin
                if (out_free)
                begin
                    load_value         = 1'b1;
                    store_req.clr_en   = 1'b1;
                    store_req.clr_addr = idx_reg;
                    if (pending_above == '0)
                    begin
                        state_next = arrss_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + arrss_pkg::CH_BITS'(1);
                        state_next = arrss_pkg::ST_DRAIN_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = arrss_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arrss_pkg::ST_IDLE;
            cur_reg   <= '0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            mask_reg  <= '0;
            first_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            if (cfg_we && (cfg_index == arrss_pkg::CFG_ENABLED_MASK))
            begin
                mask_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == arrss_pkg::CFG_FIRST_CHANNEL))
            begin
                first_reg <= cfg_data[arrss_pkg::CH_BITS-1:0];
            end
        end
    end

    // Output valid: set on a load, drop once the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_report || load_value)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load_report)
        begin
            kind_reg         <= arrss_pkg::KIND_REPORT;
            next_channel_reg <= idx_reg;
            round_done_reg   <= (idx_reg == first_reg);
            channel_reg      <= '0;
            value_reg        <= '0;
            last_reg         <= 1'b1;
        end
        else if (load_value)
        begin
            kind_reg         <= arrss_pkg::KIND_VALUE;
            next_channel_reg <= '0;
            round_done_reg   <= 1'b0;
            channel_reg      <= idx_reg;
            value_reg        <= rd_data;
            last_reg         <= (pending_above == '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign next_channel = next_channel_reg;
    assign round_done   = round_done_reg;
    assign channel      = channel_reg;
    assign value        = value_reg;
    assign last         = last_reg;

endmodule

@@ rtl/arrss_chan_store.sv @@
// ----------------------------------------------------------------------------
// arrss_chan_store: per-channel sample store with pending marks
// Holds the last sample of each channel, one write and one registered read
// per cycle, and a pending bit per channel that a write sets and a clear drops.
// ----------------------------------------------------------------------------
module arrss_chan_store (
    input  logic                                clk,
    input  logic                                rst_n,
    input  arrss_pkg::store_req_t               req,
    input  logic [arrss_pkg::SAMPLE_BITS-1:0]   wr_data,
    output logic [arrss_pkg::SAMPLE_BITS-1:0]   rd_data,
    output logic [arrss_pkg::NUM_CHANNELS-1:0]  pending
);

    logic [arrss_pkg::SAMPLE_BITS-1:0]  value_mem [arrss_pkg::NUM_CHANNELS];
    logic [arrss_pkg::SAMPLE_BITS-1:0]  rd_data_reg;
    logic [arrss_pkg::NUM_CHANNELS-1:0] pending_reg;
    logic [arrss_pkg::NUM_CHANNELS-1:0] pending_next;

    // Write the sample and register the read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            value_mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= value_mem[req.rd_addr];
        end
    end

    // Set the mark on a write, drop it on a clear
    always_comb
    begin
        pending_next = pending_reg;
        if (req.wr_en)
        begin
            pending_next[req.wr_addr] = 1'b1;
        end
        if (req.clr_en)
        begin
            pending_next[req.clr_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    assign rd_data = rd_data_reg;
    assign pending = pending_reg;

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ADC round-robin scan sequencer
// Drives conversion and drain transfers, with random gaps and stalls on both
// channels, through several mask and first-channel settings. A behavioural
// copy of the sequencer predicts every report and delivered value, and each
// output transfer is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int QUIET_LIMIT  = 4000;  // cycles with no transfer before giving up
    localparam int PRESS_CYCLES = 300;   // long receiver hold-off
    localparam int SETTLE       = 16;    // covers an empty drain still in flight
    localparam int SET_ITEMS    = 39;    // random items per register setting

    // One output transfer of the sequencer
    typedef struct packed {
        logic                              kind;
        logic [arrss_pkg::CH_BITS-1:0]     next_ch;
        logic                              rd;
        logic [arrss_pkg::CH_BITS-1:0]     ch;
        logic [arrss_pkg::SAMPLE_BITS-1:0] val;
        logic                              last;
    } scan_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} chk_t;

    // One line of the directed stimulus
    typedef struct packed {
        row_kind_t                         rk;
        logic [arrss_pkg::MASK_BITS-1:0]   mask_d;
        logic [arrss_pkg::MASK_BITS-1:0]   first_d;
        logic                              op;
        logic [arrss_pkg::SAMPLE_BITS-1:0] smp;
        chk_t                              chk;
        scan_result_t                      res;
    } row_t;

    localparam int DIR_ROWS = 24;
    localparam scan_result_t NO_RES = '0;

    // Directed stimulus: reset values first, then all channels, a lone top
    // channel with an out-of-range first channel, a lone bottom channel and
    // finally no channel enabled
    row_t dir_tab [DIR_ROWS] = '{
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_CONVERT, 10'h000, CHK_TYPED,
          '{arrss_pkg::KIND_REPORT, 3'd0, 1'b1, 3'd0, 10'h000, 1'b1}},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_DRAIN,   10'h000, CHK_TYPED,
          '{arrss_pkg::KIND_VALUE,  3'd0, 1'b0, 3'd0, 10'h000, 1'b1}},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_DRAIN,   10'h3FF, CHK_NONE,  NO_RES},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_CONVERT, 10'h3FF, CHK_TYPED,
          '{arrss_pkg::KIND_REPORT, 3'd0, 1'b1, 3'd0, 10'h000, 1'b1}},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_DRAIN,   10'h000, CHK_TYPED,
          '{arrss_pkg::KIND_VALUE,  3'd0, 1'b0, 3'd0, 10'h3FF, 1'b1}},
        '{ROW_CFG,  6'h3F, 6'h05, arrss_pkg::OP_CONVERT, 10'h000, CHK_NONE,  NO_RES},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_CONVERT, 10'h2AA, CHK_TYPED,
          '{arrss_pkg::KIND_REPORT, 3'd1, 1'b0, 3'd0, 10'h000, 1'b1}},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_CONVERT, 10'h155, CHK_MODEL, NO_RES},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_CONVERT, 10'h3FF, CHK_MODEL, NO_RES},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_CONVERT, 10'h000, CHK_MODEL, NO_RES},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_CONVERT, 10'h0F0, CHK_TYPED,
          '{arrss_pkg::KIND_REPORT, 3'd5, 1'b1, 3'd0, 10'h000, 1'b1}},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_CONVERT, 10'h30F, CHK_TYPED,
          '{arrss_pkg::KIND_REPORT, 3'd0, 1'b0, 3'd0, 10'h000, 1'b1}},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_DRAIN,   10'h000, CHK_MODEL, NO_RES},
        '{ROW_CFG,  6'h20, 6'h3F, arrss_pkg::OP_CONVERT, 10'h000, CHK_NONE,  NO_RES},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_CONVERT, 10'h201, CHK_TYPED,
          '{arrss_pkg::KIND_REPORT, 3'd5, 1'b0, 3'd0, 10'h000, 1'b1}},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_CONVERT, 10'h1FE, CHK_TYPED,
          '{arrss_pkg::KIND_REPORT, 3'd5, 1'b0, 3'd0, 10'h000, 1'b1}},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_DRAIN,   10'h000, CHK_MODEL, NO_RES},
        '{ROW_CFG,  6'h01, 6'h30, arrss_pkg::OP_CONVERT, 10'h000, CHK_NONE,  NO_RES},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_CONVERT, 10'h2AA, CHK_TYPED,
          '{arrss_pkg::KIND_REPORT, 3'd0, 1'b1, 3'd0, 10'h000, 1'b1}},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_CONVERT, 10'h155, CHK_TYPED,
          '{arrss_pkg::KIND_REPORT, 3'd0, 1'b1, 3'd0, 10'h000, 1'b1}},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_DRAIN,   10'h000, CHK_MODEL, NO_RES},
        '{ROW_CFG,  6'h00, 6'h0E, arrss_pkg::OP_CONVERT, 10'h000, CHK_NONE,  NO_RES},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_CONVERT, 10'h3FF, CHK_TYPED,
          '{arrss_pkg::KIND_REPORT, 3'd0, 1'b0, 3'd0, 10'h000, 1'b1}},
        '{ROW_ITEM, 6'h00, 6'h00, arrss_pkg::OP_DRAIN,   10'h000, CHK_TYPED,
          '{arrss_pkg::KIND_VALUE,  3'd0, 1'b0, 3'd0, 10'h3FF, 1'b1}}
    };

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    // Block ports, all driven from time zero
    logic                               in_valid  = 1'b0;
    logic                               in_stall;
    logic                               opcode    = arrss_pkg::OP_CONVERT;
    logic [arrss_pkg::SAMPLE_BITS-1:0]  sample    = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic                               kind;
    logic [arrss_pkg::CH_BITS-1:0]      next_channel;
    logic                               round_done;
    logic [arrss_pkg::CH_BITS-1:0]      channel;
    logic [arrss_pkg::SAMPLE_BITS-1:0]  value;
    logic                               last;
    logic                               cfg_we    = 1'b0;
    logic [arrss_pkg::CFG_IDX_BITS-1:0] cfg_index = arrss_pkg::CFG_ENABLED_MASK;
    logic [arrss_pkg::MASK_BITS-1:0]    cfg_data  = '0;

    adc_round_robin_scan_sequencer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .next_channel (next_channel),
        .round_done   (round_done),
        .channel      (channel),
        .value        (value),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Behavioural copy of the sequencer state and registers
    logic [arrss_pkg::MASK_BITS-1:0]   sc_mask  = '0;
    logic [arrss_pkg::CH_BITS-1:0]     sc_first = '0;
    logic [arrss_pkg::CH_BITS-1:0]     sc_cur   = '0;
    logic [arrss_pkg::SAMPLE_BITS-1:0] sc_samples [arrss_pkg::NUM_CHANNELS];
    bit [arrss_pkg::NUM_CHANNELS-1:0]  sc_marked = '0;

    scan_result_t seq_results_q [$];

    int fault_cnt    = 0;
    int quiet_cnt    = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    bit press_req    = 1'b0;

    scan_result_t want_res;
    scan_result_t got_res;

    // Advance the sequencer copy by one accepted input and queue its results
    task automatic scan_step(input logic op, input logic [arrss_pkg::SAMPLE_BITS-1:0] smp,
                             input chk_t chk, input scan_result_t typed);
        scan_result_t                  r;
        scan_result_t                  batch [$];
        logic [arrss_pkg::CH_BITS-1:0] nxt;
        logic [arrss_pkg::CH_BITS-1:0] cand;
        bit                            hit;
        int                            k;
        if (op == arrss_pkg::OP_CONVERT)
        begin
            // store the sample, then search upward from the current channel
            sc_samples[sc_cur] = smp;
            sc_marked[sc_cur]  = 1'b1;
            nxt = sc_cur;
            hit = 1'b0;
            for (k = 1; k <= arrss_pkg::NUM_CHANNELS; k++)
            begin
                cand = arrss_pkg::CH_BITS'((sc_cur + k) % arrss_pkg::NUM_CHANNELS);
                if (!hit && sc_mask[cand])
                begin
                    nxt = cand;
                    hit = 1'b1;
                end
            end
            sc_cur    = nxt;
            r         = '0;
            r.kind    = arrss_pkg::KIND_REPORT;
            r.next_ch = nxt;
            r.rd      = (nxt == sc_first);
            r.last    = 1'b1;
            batch.push_back(r);
        end
        else
        begin
            // deliver every marked channel in ascending order
            for (k = 0; k < arrss_pkg::NUM_CHANNELS; k++)
            begin
                if (sc_marked[k])
                begin
                    r      = '0;
                    r.kind = arrss_pkg::KIND_VALUE;
                    r.ch   = arrss_pkg::CH_BITS'(k);
                    r.val  = sc_samples[k];
                    batch.push_back(r);
                    sc_marked[k] = 1'b0;
                end
            end
            if (batch.size() > 0)
            begin
                batch[batch.size()-1].last = 1'b1;
            end
        end
        if (chk == CHK_MODEL)
        begin
            foreach (batch[k])
            begin
                seq_results_q.push_back(batch[k]);
            end
        end
        else if (chk == CHK_TYPED)
        begin
            seq_results_q.push_back(typed);
        end
    endtask

    // Offer one input transfer; called just after a falling edge
    task automatic offer_item(input logic op, input logic [arrss_pkg::SAMPLE_BITS-1:0] smp,
                              input chk_t chk, input scan_result_t typed);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        sample   <= smp;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        scan_step(op, smp, chk, typed);
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted result has been delivered
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (seq_results_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write both registers on consecutive cycles
    task automatic write_cfg(input logic [arrss_pkg::MASK_BITS-1:0] mask_d,
                             input logic [arrss_pkg::MASK_BITS-1:0] first_d);
        cfg_we    <= 1'b1;
        cfg_index <= arrss_pkg::CFG_ENABLED_MASK;
        cfg_data  <= mask_d;
        @(negedge clk);
        cfg_index <= arrss_pkg::CFG_FIRST_CHANNEL;
        cfg_data  <= first_d;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sc_mask  = mask_d;
        sc_first = first_d[arrss_pkg::CH_BITS-1:0];
    endtask

    task automatic report_fault(input string why, input scan_result_t want,
                                input scan_result_t got);
        fault_cnt++;
        if (fault_cnt <= 10)
        begin
            $display("%0t %s: want kind=%0d nxt=%0d rd=%0d ch=%0d val=%0d last=%0d",
                     $time, why, want.kind, want.next_ch, want.rd, want.ch,
                     want.val, want.last);
            $display("%0t %s: got  kind=%0d nxt=%0d rd=%0d ch=%0d val=%0d last=%0d",
                     $time, why, got.kind, got.next_ch, got.rd, got.ch,
                     got.val, got.last);
        end
    endtask

    // Receiver: random stall, plus one long hold-off on request
    initial
    begin : receiver
        bit press_taken;
        press_taken = 1'b0;
        forever
        begin
            @(negedge clk);
            if (press_req && !press_taken)
            begin
                press_taken = 1'b1;
                out_stall <= 1'b1;
                repeat (PRESS_CYCLES) @(negedge clk);
            end
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // Compare each output transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_res = '{kind, next_channel, round_done, channel, value, last};
            if (seq_results_q.size() == 0)
            begin
                report_fault("unexpected result", NO_RES, got_res);
            end
            else
            begin
                want_res = seq_results_q.pop_front();
                if (got_res.kind    !== want_res.kind    ||
                    got_res.next_ch !== want_res.next_ch ||
                    got_res.rd      !== want_res.rd      ||
                    got_res.ch      !== want_res.ch      ||
                    got_res.val     !== want_res.val     ||
                    got_res.last    !== want_res.last)
                begin
                    report_fault("mismatch", want_res, got_res);
                end
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        begin
            quiet_cnt <= 0;
        end
        else
        begin
            quiet_cnt <= quiet_cnt + 1;
        end
        if (quiet_cnt >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus
    initial
    begin : stim
        int                                ph;
        int                                s;
        int                                i;
        int                                drain_pct;
        logic [arrss_pkg::MASK_BITS-1:0]   mk;
        logic [arrss_pkg::MASK_BITS-1:0]   fd;
        logic [arrss_pkg::SAMPLE_BITS-1:0] smp;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // walk the directed table; register rows wait for the block to go idle
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].rk == ROW_CFG)
            begin
                wait_idle();
                write_cfg(dir_tab[i].mask_d, dir_tab[i].first_d);
            end
            else
            begin
                offer_item(dir_tab[i].op, dir_tab[i].smp, dir_tab[i].chk,
                           dir_tab[i].res);
            end
        end

        // random part: receiver-idle, sender-idle, then back-to-back phases
        for (ph = 0; ph < 3; ph++)
        begin
            snd_idle_pct <= (ph == 0) ? 33 : (ph == 1) ? 88 : 0;
            rcv_idle_pct <= (ph == 0) ? 88 : (ph == 1) ? 33 : 0;
            for (s = 0; s < 4; s++)
            begin
                wait_idle();
                case (s)
                    0:       mk = '1;
                    1:       mk = arrss_pkg::MASK_BITS'(1)
                                  << $urandom_range(arrss_pkg::NUM_CHANNELS - 1);
                    3:       mk = (ph == 0) ? '0 : arrss_pkg::MASK_BITS'($urandom);
                    default: mk = arrss_pkg::MASK_BITS'($urandom);
                endcase
                fd = {3'($urandom),
                      (s == 0) ? arrss_pkg::LAST_CH
                               : arrss_pkg::CH_BITS'($urandom_range(7))};
                write_cfg(mk, fd);
                // hold the receiver off while the sender keeps offering
                if (ph == 2 && s == 0)
                begin
                    press_req <= 1'b1;
                end
                drain_pct = $urandom_range(5, 40);
                for (i = 0; i < SET_ITEMS; i++)
                begin
                    case ($urandom_range(9))
                        0:       smp = '0;
                        1:       smp = '1;
                        default: smp = arrss_pkg::SAMPLE_BITS'($urandom);
                    endcase
                    offer_item(($urandom_range(99) < drain_pct) ? arrss_pkg::OP_DRAIN
                                                                : arrss_pkg::OP_CONVERT,
                               smp, CHK_MODEL, NO_RES);
                end
            end
        end

        wait_idle();
        if (fault_cnt == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/arrss_pkg.sv
rtl/arrss_chan_store.sv
rtl/adc_round_robin_scan_sequencer.sv
tb/sv/tb_top.sv
